// File: design/srp_pkg.sv
package srp_pkg;

  // field and register widths
  localparam int DelayW   = 16;
  localparam int CountW   = 32;
  localparam int RampW    = 31;
  localparam int CfgDataW = 31;
  localparam int CfgIdxW  = 2;
  localparam int OpW      = 2;
  localparam int PhaseW   = 2;
  localparam int InDataW  = 32;
  localparam int OutDataW = 24;

  // divider: 33-bit dividend magnitude, one quotient bit per cycle
  localparam int NumMagW  = 33;
  localparam int DivCntW  = 6;
  localparam logic [DivCntW-1:0] DivLastCnt = DivCntW'(NumMagW - 1);

  // operation codes
  localparam logic [OpW-1:0] OP_START = 2'd0;
  localparam logic [OpW-1:0] OP_TICK  = 2'd1;
  localparam logic [OpW-1:0] OP_STOP  = 2'd2;

  // register indexes
  localparam logic [CfgIdxW-1:0] CFG_FIRST_DELAY = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_RAMP_STEPS  = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_FLOOR_DELAY = 2'd2;

  typedef enum logic [PhaseW-1:0] {
    PH_IDLE   = 2'd0,
    PH_ACCEL  = 2'd1,
    PH_CRUISE = 2'd2,
    PH_DECEL  = 2'd3
  } phase_t;

  typedef struct packed {
    logic capture;
    logic prep;
    logic div_step;
    logic fix;
    logic commit;
  } srp_cmd_t;

  typedef struct packed {
    logic need_div;
    logic div_last;
    logic out_free;
  } srp_status_t;

endpackage

// File: design/srp_ctrl.sv
module srp_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  srp_pkg::srp_status_t status,
  output srp_pkg::srp_cmd_t   cmd
);
  import srp_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_PREP   = 5'b00010,
    ST_DIV    = 5'b00100,
    ST_FIX    = 5'b01000,
    ST_COMMIT = 5'b10000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd.prep   = 1'b1;
        state_next = status.need_div ? ST_DIV : ST_COMMIT;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = ST_FIX;
        end
      end
      ST_FIX: begin
        cmd.fix    = 1'b1;
        state_next = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (status.out_free) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// File: design/srp_datapath.sv
module srp_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  srp_pkg::srp_cmd_t             cmd,
  output srp_pkg::srp_status_t          status,
  input  logic [srp_pkg::OpW-1:0]       in_op,
  input  logic [srp_pkg::CountW-1:0]    in_len,
  input  logic                          cfg_we,
  input  logic [srp_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [srp_pkg::CfgDataW-1:0]  cfg_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [srp_pkg::OutDataW-1:0]  out_data,
  output logic                          out_last
);
  import srp_pkg::*;

  // config
  logic [DelayW-1:0] first_delay;
  logic [RampW-1:0]  ramp_steps;
  logic [DelayW-1:0] floor_delay;

  // captured item
  logic [OpW-1:0]    op_q;
  logic [CountW-1:0] len_q;

  // profile state
  logic [CountW-1:0] step_total, step_index, ramp_count, carry_rem;
  logic [CountW-1:0] accel_end, decel_begin;
  logic [DelayW-1:0] cur_delay;
  phase_t            mode;
  logic              trap_flag;

  logic [CountW-1:0] step_total_next, step_index_next, ramp_count_next, carry_rem_next;
  logic [CountW-1:0] accel_end_next, decel_begin_next;
  logic [DelayW-1:0] cur_delay_next;
  phase_t            mode_next;
  logic              trap_flag_next;
  logic              done_next;

  // incremented counters, registered in prep
  logic [CountW-1:0] si_inc, rc_inc;

  // divider
  logic                num_neg, den_neg;
  logic [CountW-1:0]   dmag;
  logic [NumMagW-1:0]  quo;
  logic [CountW-1:0]   rem;
  logic [DivCntW-1:0]  div_cnt;
  logic [NumMagW:0]    q_s;     // signed quotient
  logic [CountW-1:0]   r_s;     // signed remainder

  logic [NumMagW:0]    num_w;
  logic [NumMagW:0]    num_neg_w;
  logic [CountW-1:0]   den_w;
  logic [NumMagW-1:0]  sh;
  logic                ge;

  logic [NumMagW+2:0]  nd;
  logic [DelayW-1:0]   nd_sat;

  // config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      first_delay <= '1;
      ramp_steps  <= '0;
      floor_delay <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FIRST_DELAY: first_delay <= cfg_data[DelayW-1:0];
        CFG_RAMP_STEPS:  ramp_steps  <= cfg_data[RampW-1:0];
        CFG_FLOOR_DELAY: floor_delay <= cfg_data[DelayW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q  <= in_op;
      len_q <= in_len;
    end
  end

  assign status.need_div = (op_q == OP_TICK) && ((mode == PH_ACCEL) || (mode == PH_DECEL));
  assign status.div_last = (div_cnt == DivLastCnt);
  assign status.out_free = !out_valid || out_ready;

  // operands: num = 2*delay + rem, den = 4*n + 1 (mod 2^32)
  assign num_w     = {{(NumMagW-DelayW){1'b0}}, cur_delay, 1'b0}
                   + {{2{carry_rem[CountW-1]}}, carry_rem};
  assign num_neg_w = '0 - num_w;
  assign den_w     = {ramp_count[CountW-3:0], 2'b01};

  assign sh = {rem, quo[NumMagW-1]};
  assign ge = (sh >= {1'b0, dmag});

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      si_inc  <= step_index + CountW'(1);
      rc_inc  <= ramp_count + CountW'(1);
      num_neg <= num_w[NumMagW];
      den_neg <= den_w[CountW-1];
      quo     <= num_w[NumMagW] ? num_neg_w[NumMagW-1:0] : num_w[NumMagW-1:0];
      dmag    <= den_w[CountW-1] ? ('0 - den_w) : den_w;
      rem     <= '0;
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      rem     <= ge ? CountW'(sh - {1'b0, dmag}) : sh[CountW-1:0];
      quo     <= {quo[NumMagW-2:0], ge};
      div_cnt <= div_cnt + DivCntW'(1);
    end
    if (cmd.fix) begin
      q_s <= (num_neg ^ den_neg) ? ('0 - {1'b0, quo}) : {1'b0, quo};
      r_s <= num_neg ? ('0 - rem) : rem;
    end
  end

  // delay update with saturation at floor and at full scale
  assign nd = {{(NumMagW+3-DelayW){1'b0}}, cur_delay} - {{2{q_s[NumMagW]}}, q_s};

  always_comb begin
    if ($signed(nd) < $signed({{(NumMagW+3-DelayW){1'b0}}, floor_delay})) begin
      nd_sat = floor_delay;
    end else if ($signed(nd) > $signed({{(NumMagW+3-DelayW){1'b0}}, {DelayW{1'b1}}})) begin
      nd_sat = '1;
    end else begin
      nd_sat = nd[DelayW-1:0];
    end
  end

  always_comb begin
    step_total_next  = step_total;
    step_index_next  = step_index;
    ramp_count_next  = ramp_count;
    carry_rem_next   = carry_rem;
    accel_end_next   = accel_end;
    decel_begin_next = decel_begin;
    cur_delay_next   = cur_delay;
    mode_next        = mode;
    trap_flag_next   = trap_flag;
    done_next        = 1'b0;
    case (op_q)
      OP_START: begin
        step_total_next = len_q;
        step_index_next = '0;
        ramp_count_next = CountW'(1);
        carry_rem_next  = '0;
        if ({ramp_steps, 1'b0} < len_q) begin
          trap_flag_next   = 1'b1;
          accel_end_next   = {1'b0, ramp_steps};
          decel_begin_next = len_q - {1'b0, ramp_steps};
        end else begin
          trap_flag_next   = 1'b0;
          accel_end_next   = len_q >> 1;
          decel_begin_next = len_q - (len_q >> 1);
        end
        cur_delay_next = first_delay;
        mode_next      = PH_ACCEL;
      end
      OP_TICK: begin
        step_index_next = si_inc;
        case (mode)
          PH_ACCEL: begin
            cur_delay_next  = nd_sat;
            carry_rem_next  = r_s;
            ramp_count_next = rc_inc;
            if (trap_flag) begin
              if (si_inc >= accel_end) begin
                mode_next = PH_CRUISE;
              end
            end else if (si_inc >= decel_begin) begin
              mode_next       = PH_DECEL;
              ramp_count_next = '0 - rc_inc;
            end
          end
          PH_CRUISE: begin
            if (si_inc >= decel_begin) begin
              mode_next       = PH_DECEL;
              ramp_count_next = '0 - ramp_count;
            end
          end
          PH_DECEL: begin
            cur_delay_next  = nd_sat;
            carry_rem_next  = r_s;
            ramp_count_next = rc_inc;
            if (si_inc >= step_total) begin
              mode_next = PH_IDLE;
              done_next = 1'b1;
            end
          end
          default: ;
        endcase
      end
      OP_STOP: begin
        mode_next = PH_IDLE;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step_total  <= '0;
      step_index  <= '0;
      ramp_count  <= CountW'(1);
      carry_rem   <= '0;
      accel_end   <= '0;
      decel_begin <= '0;
      cur_delay   <= '0;
      mode        <= PH_IDLE;
      trap_flag   <= 1'b0;
    end else if (cmd.commit) begin
      step_total  <= step_total_next;
      step_index  <= step_index_next;
      ramp_count  <= ramp_count_next;
      carry_rem   <= carry_rem_next;
      accel_end   <= accel_end_next;
      decel_begin <= decel_begin_next;
      cur_delay   <= cur_delay_next;
      mode        <= mode_next;
      trap_flag   <= trap_flag_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_data <= {{(OutDataW-DelayW-PhaseW-1){1'b0}}, trap_flag_next,
                   PhaseW'(mode_next), cur_delay_next};
      out_last <= done_next;
    end
  end

endmodule

// File: design/stepper_ramp_profile_unit.sv
// Sequence: start, stop, idle or cruise tick: capture, operand prep, then commit into the output register;
//   accelerate or decelerate tick: capture, prep, the 33-step serial divider, sign fixup, then commit.
// Items: one at a time; commit waits until the output register is free, and the next input
//   transfer is taken once the current result is in the output register.
// Reset (rst, synchronous, active high): phase idle, counters cleared, ramp count 1,
//   registers back to first_delay 65535, ramp_steps 0, floor_delay 0.
module stepper_ramp_profile_unit (
  input  logic                          clk,
  input  logic                          rst,
  // input stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [srp_pkg::InDataW-1:0]   s_axis_tdata,   // [31:0] move_length
  input  logic [srp_pkg::OpW-1:0]       s_axis_tuser,   // [1:0] operation
  // result stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [srp_pkg::OutDataW-1:0]  m_axis_tdata,   // [15:0] period, [17:16] phase,
                                                        // [18] is_trapezoid, [23:19] zero
  output logic                          m_axis_tlast,   // move_done
  // register writes
  input  logic                          cfg_we,
  input  logic [srp_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [srp_pkg::CfgDataW-1:0]  cfg_data
);
  import srp_pkg::*;

  srp_cmd_t    cmd;
  srp_status_t status;

  // Controller sequences capture, operand prep, divide, sign fixup and commit.
  srp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // Datapath holds the profile state, the serial divider and the output register.
  // Delay recurrence: q = (2*delay + rem) / (4n+1), truncated toward zero,
  // remainder carried; new delay saturates at floor_delay and 65535.
  srp_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_op     (s_axis_tuser),
    .in_len    (s_axis_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata),
    .out_last  (m_axis_tlast)
  );

endmodule

// File: design/srp_checker.sv
module srp_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [srp_pkg::OutDataW-1:0]  m_axis_tdata,
  input logic                          m_axis_tlast
);
  import srp_pkg::*;

  // result stays offered until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped before transfer");

  // one item in flight: input closes right after a transfer
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while an item is in flight");

  // end of move always lands in idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[17:16] == PH_IDLE)
    else $error("move_done without idle phase");

  // cruise only exists on a trapezoid
  a_cruise_trap: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tdata[17:16] == PH_CRUISE) |-> m_axis_tdata[18])
    else $error("cruise on triangular profile");

  // nothing offered right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

endmodule

bind stepper_ramp_profile_unit srp_checker u_srp_checker (.*);

// File: test/tb_stepper_ramp_profile_unit.sv
`timescale 1ns / 1ps

module tb_stepper_ramp_profile_unit;
  import srp_pkg::*;

  // operation code the block must ignore, and a register index past the list
  localparam logic [OpW-1:0]     OP_UNUSED = 2'd3;
  localparam logic [CfgIdxW-1:0] CFG_NONE  = 2'd3;

  // one result as the block reports it
  typedef struct packed {
    logic [DelayW-1:0] period;
    phase_t            phase;
    logic              trap;
    logic              done;
  } profile_out_t;

  logic                 clk;
  logic                 rst;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [InDataW-1:0]   s_axis_tdata;
  logic [OpW-1:0]       s_axis_tuser;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [OutDataW-1:0]  m_axis_tdata;
  logic                 m_axis_tlast;
  logic                 cfg_we;
  logic [CfgIdxW-1:0]   cfg_index;
  logic [CfgDataW-1:0]  cfg_data;

  stepper_ramp_profile_unit DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Profile predictor: own copy of the registers and the ramp state,
  // advanced once per accepted input transfer.
  // ---------------------------------------------------------------------------
  logic [DelayW-1:0] cfg_first  = 16'hFFFF;
  logic [RampW-1:0]  cfg_ramp   = '0;
  logic [DelayW-1:0] cfg_floor  = '0;

  logic [CountW-1:0] mv_total    = '0;
  logic [CountW-1:0] mv_index    = '0;
  logic [CountW-1:0] slope_n     = 32'd1;  // signed ramp counter n
  logic [CountW-1:0] rem_acc     = '0;     // signed carried remainder
  logic [DelayW-1:0] delay_q     = '0;
  phase_t            phase_q     = PH_IDLE;
  logic              trap_q      = 1'b0;
  logic [CountW-1:0] accel_stop  = '0;
  logic [CountW-1:0] decel_start = '0;

  profile_out_t expected_profile[$];

  int  items_sent = 0;
  int  mismatches = 0;
  bit  no_idle    = 1'b0;   // set for stretches with back-to-back transfers

  // delay -= (2*delay + rem) / (4n + 1), remainder carried, result clamped
  // to [floor, 65535]; signed division truncates toward zero
  task automatic update_period();
    longint            num;
    longint            den;
    longint            quo;
    longint            rmd;
    longint            nd;
    logic [CountW-1:0] den32;
    num   = 2 * longint'(delay_q) + longint'($signed(rem_acc));
    den32 = slope_n * 32'd4 + 32'd1;
    den   = longint'($signed(den32));
    quo   = num / den;
    rmd   = num % den;
    nd    = longint'(delay_q) - quo;
    if (nd < longint'(cfg_floor)) nd = longint'(cfg_floor);
    if (nd > 65535) nd = 65535;
    delay_q = nd[DelayW-1:0];
    rem_acc = rmd[CountW-1:0];
    slope_n = slope_n + 32'd1;
  endtask

  task automatic advance_profile(input logic [OpW-1:0] op, input logic [InDataW-1:0] len);
    profile_out_t res;
    logic         done;
    done = 1'b0;
    case (op)
      OP_START: begin
        mv_total = len;
        mv_index = '0;
        slope_n  = 32'd1;
        rem_acc  = '0;
        // trapezoid when 2*ramp_steps < length (no overflow at 32 bits)
        if ({cfg_ramp, 1'b0} < len) begin
          trap_q      = 1'b1;
          accel_stop  = {1'b0, cfg_ramp};
          decel_start = len - {1'b0, cfg_ramp};
        end else begin
          trap_q      = 1'b0;
          accel_stop  = len >> 1;
          decel_start = len - (len >> 1);
        end
        delay_q = cfg_first;
        phase_q = PH_ACCEL;
      end
      OP_TICK: begin
        mv_index = mv_index + 32'd1;
        case (phase_q)
          PH_ACCEL: begin
            update_period();
            if (trap_q) begin
              if (mv_index >= accel_stop) phase_q = PH_CRUISE;
            end else if (mv_index >= decel_start) begin
              phase_q = PH_DECEL;
              slope_n = 32'd0 - slope_n;
            end
          end
          PH_CRUISE: begin
            if (mv_index >= decel_start) begin
              phase_q = PH_DECEL;
              slope_n = 32'd0 - slope_n;
            end
          end
          PH_DECEL: begin
            update_period();
            if (mv_index >= mv_total) begin
              phase_q = PH_IDLE;
              done    = 1'b1;
            end
          end
          default: ;  // idle tick: only the index moves
        endcase
      end
      OP_STOP: phase_q = PH_IDLE;
      default: ;    // unused code leaves everything alone
    endcase
    res.period = delay_q;
    res.phase  = phase_q;
    res.trap   = trap_q;
    res.done   = done;
    expected_profile.push_back(res);
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic int draw_gap();
    if (no_idle) return 0;
    return int'($urandom_range(0, 15));
  endfunction

  // One input transfer. Valid stays high into the next item when no gap is
  // drawn, so it is never dropped and raised in the same step.
  task automatic send_item(input logic [OpW-1:0] op, input logic [InDataW-1:0] len);
    int gap;
    gap = draw_gap();
    @(negedge clk);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= $urandom;
      s_axis_tuser  <= OpW'($urandom_range(0, 3));
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= len;
    s_axis_tuser  <= op;
    do @(posedge clk); while (!s_axis_tready);
    advance_profile(op, len);
    items_sent++;
  endtask

  // Drop valid and wait until every expected result has been transferred;
  // each item yields exactly one result, so the block is idle afterwards.
  task automatic drain_results();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (expected_profile.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      CFG_FIRST_DELAY: cfg_first = val[DelayW-1:0];
      CFG_RAMP_STEPS:  cfg_ramp  = val[RampW-1:0];
      CFG_FLOOR_DELAY: cfg_floor = val[DelayW-1:0];
      default: ;
    endcase
  endtask

  // Tick a running move until it goes idle or the cap is hit.
  task automatic tick_until_idle(input int cap);
    int n;
    n = 0;
    while (phase_q != PH_IDLE && n < cap) begin
      send_item(OP_TICK, $urandom);
      n++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // tick, stop and the unused code straight after reset
  task automatic test_idle_ops();
    send_item(OP_TICK, 32'hFFFF_FFFF);
    send_item(OP_STOP, 32'h0);
    send_item(OP_UNUSED, 32'hA5A5_5A5A);
  endtask

  // zero-length move: decelerate on the first tick, done on the second
  task automatic test_zero_length();
    drain_results();
    write_reg(CFG_FIRST_DELAY, 31'h0000_FFFF);
    write_reg(CFG_RAMP_STEPS, 31'h0);
    write_reg(CFG_FLOOR_DELAY, 31'h0);
    send_item(OP_START, 32'h0);
    send_item(OP_TICK, 32'h0);
    send_item(OP_TICK, 32'h0);
    send_item(OP_TICK, 32'h0);
  endtask

  // largest ramp and length: trapezoid at all-ones, triangle one below;
  // unused code and stop in the middle of a move
  task automatic test_full_length();
    drain_results();
    write_reg(CFG_RAMP_STEPS, 31'h7FFF_FFFF);
    write_reg(CFG_NONE, 31'h5555_5555);
    send_item(OP_START, 32'hFFFF_FFFF);
    send_item(OP_TICK, 32'h0);
    send_item(OP_UNUSED, 32'h0);
    send_item(OP_TICK, 32'h0);
    send_item(OP_STOP, 32'h0);
    send_item(OP_START, 32'hFFFF_FFFE);
    send_item(OP_TICK, 32'h0);
    send_item(OP_STOP, 32'h0);
  endtask

  // delay bounds: minimum first delay, clamp at a high floor, growth past 65535
  task automatic test_delay_bounds();
    drain_results();
    write_reg(CFG_RAMP_STEPS, 31'h0);
    write_reg(CFG_FIRST_DELAY, 31'h7FFF_0001);   // upper bits dropped
    write_reg(CFG_FLOOR_DELAY, 31'h0);
    send_item(OP_START, 32'd3);
    tick_until_idle(8);
    drain_results();
    write_reg(CFG_FIRST_DELAY, 31'h0000_FFFF);
    write_reg(CFG_FLOOR_DELAY, 31'd60000);
    send_item(OP_START, 32'd2);
    tick_until_idle(6);
    drain_results();
    write_reg(CFG_FIRST_DELAY, 31'h1);
    write_reg(CFG_FLOOR_DELAY, 31'h7FFF_FFFF);   // floor 65535
    send_item(OP_START, 32'd1);
    tick_until_idle(6);
  endtask

  task automatic randomize_registers();
    logic [DelayW-1:0] fd;
    logic [DelayW-1:0] fl;
    logic [RampW-1:0]  rs;
    case ($urandom_range(0, 3))
      0:       fd = 16'd1;
      1:       fd = 16'hFFFF;
      default: fd = DelayW'($urandom_range(1, 65535));
    endcase
    case ($urandom_range(0, 5))
      0:       rs = '0;
      1:       rs = 31'h7FFF_FFFF;
      2:       rs = RampW'($urandom);
      default: rs = RampW'($urandom_range(0, 12));
    endcase
    case ($urandom_range(0, 5))
      0:       fl = '0;
      1:       fl = 16'hFFFF;
      2:       fl = DelayW'($urandom);
      default: fl = DelayW'($urandom_range(0, fd / 4));
    endcase
    write_reg(CFG_FIRST_DELAY, {15'($urandom), fd});
    write_reg(CFG_RAMP_STEPS, rs);
    write_reg(CFG_FLOOR_DELAY, {15'($urandom), fl});
    if ($urandom_range(0, 5) == 0) write_reg(CFG_NONE, CfgDataW'($urandom));
  endtask

  // Mostly complete moves with random lengths, mixed with stops, restarts,
  // unused codes and idle ticks. Very long moves are cut short by a stop.
  task automatic test_random_moves();
    logic [InDataW-1:0] len;
    int                 cap;
    int                 n;
    int                 pick;
    while (items_sent < 560) begin
      if ($urandom_range(0, 3) == 0) begin
        drain_results();
        randomize_registers();
      end
      no_idle = ($urandom_range(0, 4) == 0);
      pick = int'($urandom_range(0, 9));
      if (pick < 5)
        len = $urandom_range(0, 40);
      else if (pick < 7 && cfg_ramp <= 60)
        len = {cfg_ramp, 1'b0} + 32'($urandom_range(0, 2)) - 32'd1;  // around the split
      else if (pick < 8)
        len = $urandom_range(0, 150);
      else
        len = $urandom;
      cap = (len <= 160) ? int'(len) + 4 : int'($urandom_range(1, 10));
      send_item(OP_START, len);
      n = 0;
      while (phase_q != PH_IDLE && n < cap) begin
        pick = int'($urandom_range(0, 59));
        if (pick == 0)      send_item(OP_STOP, $urandom);
        else if (pick == 1) send_item(OP_UNUSED, $urandom);
        else if (pick == 2) send_item(OP_START, $urandom_range(0, 40));
        else                send_item(OP_TICK, $urandom);
        n++;
      end
      if (phase_q != PH_IDLE) send_item(OP_STOP, $urandom);
      repeat ($urandom_range(0, 2)) send_item(OP_TICK, $urandom);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random stalls per result, checked at the rising edge
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int stall;
    m_axis_tready = 1'b0;
    wait (!rst);
    forever begin
      stall = draw_gap();
      @(negedge clk);
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
    end
  end

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch %s: expected %0h got %0h", what, want, got);
  endtask

  always @(posedge clk) begin : check_results
    profile_out_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_profile.size() == 0) begin
        report_mismatch("unexpected result", 32'h0, {8'h0, m_axis_tdata});
      end else begin
        want = expected_profile.pop_front();
        if (m_axis_tdata[15:0] !== want.period)
          report_mismatch("period", 32'(want.period), 32'(m_axis_tdata[15:0]));
        if (m_axis_tdata[17:16] !== want.phase)
          report_mismatch("phase", 32'(want.phase), 32'(m_axis_tdata[17:16]));
        if (m_axis_tdata[18] !== want.trap)
          report_mismatch("is_trapezoid", 32'(want.trap), 32'(m_axis_tdata[18]));
        if (m_axis_tdata[23:19] !== 5'b0)
          report_mismatch("pad bits", 32'h0, 32'(m_axis_tdata[23:19]));
        if (m_axis_tlast !== want.done)
          report_mismatch("move_done", 32'(want.done), 32'(m_axis_tlast));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_idle_ops();
    test_zero_length();
    test_full_length();
    test_delay_bounds();
    test_random_moves();

    drain_results();
    // room for a stray result after the last one
    repeat (50) @(posedge clk);
    if (mismatches == 0 && expected_profile.size() == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

  // watchdog: far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
